[design/rgb_to_hsv_pixel_defines.svh]
// Assertion macros used by the pixel converter RTL.
`ifndef RGB_TO_HSV_PIXEL_DEFINES_SVH
`define RGB_TO_HSV_PIXEL_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while arst_n is low.
`define RTV_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet while arst_n is low.
`define RTV_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/rtv_pkg.sv]
// Shared widths, constants and types of the pixel converter.
`timescale 1ns / 1ps
package rtv_pkg;

	localparam int CHAN_W = 8;
	localparam int NUM_W  = 2 * CHAN_W;
	localparam int N_W    = 11;
	localparam int NCELL  = CHAN_W;
	localparam int NSTAGE = NCELL + 2;

	localparam logic [N_W-1:0]    SECTOR_G    = N_W'(2);
	localparam logic [N_W-1:0]    SECTOR_B    = N_W'(4);
	localparam logic [N_W-1:0]    SECTOR_WRAP = N_W'(6);
	localparam logic [NUM_W-1:0]  HUE_SCALE   = NUM_W'(30);
	localparam logic [NUM_W-1:0]  SAT_SCALE   = NUM_W'(255);
	localparam logic [CHAN_W-1:0] HUE_MAX     = CHAN_W'(180);

	typedef struct packed {
		logic [CHAN_W-1:0] rem;
		logic [CHAN_W-1:0] num_lo;
		logic [CHAN_W-1:0] quo;
		logic [CHAN_W-1:0] den;
	} lane_t;

	typedef struct packed {
		logic              hue_zero;
		logic              sat_zero;
		logic [CHAN_W-1:0] value;
	} side_t;

endpackage

[design/rgb_to_hsv_pixel.sv]
// Top level: front stage, two chains of division cells, rounding output register.
//
//  channel | signals                      | payload
//  --------+------------------------------+---------------------------
//  input   | in_valid, in_stall (driven)  | blue, green, red
//  output  | out_valid, out_stall (taken) | hue, saturation, value
//
// One item enters per cycle while in_stall is low. Each item passes the front stage,
// eight division cells (one quotient bit each, hue and saturation side by side) and
// the rounding output register, in that order.
// Reset clears only the per-stage valid bits; the datapath is not reset.
// A stall at the output backs up stage by stage, and empty stages keep filling,
// so in_stall rises only once every stage holds an item.
`timescale 1ns / 1ps
`include "rgb_to_hsv_pixel_defines.svh"
module rgb_to_hsv_pixel
	import rtv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CHAN_W-1:0] blue,
	input  logic [CHAN_W-1:0] green,
	input  logic [CHAN_W-1:0] red,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CHAN_W-1:0] hue,
	output logic [CHAN_W-1:0] saturation,
	output logic [CHAN_W-1:0] value
);

	logic [NSTAGE-1:0] v_q;
	logic [NSTAGE-1:0] en;
	lane_t             hue_lane [0:NCELL];
	lane_t             sat_lane [0:NCELL];
	side_t             side_s1;
	side_t             side_q [0:NCELL-1];
	logic [CHAN_W-1:0] hue_q;
	logic [CHAN_W-1:0] sat_q;
	logic [CHAN_W-1:0] value_q;
	logic [CHAN_W:0]   hue_twice;
	logic [CHAN_W:0]   hue_den;
	logic [CHAN_W:0]   sat_twice;
	logic [CHAN_W:0]   sat_den;
	logic              hue_up;
	logic              sat_up;
	logic [CHAN_W-1:0] hue_rnd;
	logic [CHAN_W-1:0] sat_rnd;

	// A stage may load when it is empty or its item moves on this cycle.
	assign en[NSTAGE-1] = ~v_q[NSTAGE-1] | ~out_stall;
	genvar gi;
	generate
		for (gi = 0; gi < NSTAGE - 1; gi++) begin : g_en
			assign en[gi] = ~v_q[gi] | en[gi+1];
		end
	endgenerate

	assign in_stall = ~en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int i = 0; i < NSTAGE; i++) begin
				if (en[i]) begin
					v_q[i] <= (i == 0) ? in_valid : v_q[(i == 0) ? 0 : i - 1];
				end
			end
		end
	end

	rtv_front u_front (
		.clk         (clk),
		.en          (en[0]),
		.blue        (blue),
		.green       (green),
		.red         (red),
		.hue_lane_s1 (hue_lane[0]),
		.sat_lane_s1 (sat_lane[0]),
		.side_s1     (side_s1)
	);

	generate
		for (gi = 0; gi < NCELL; gi++) begin : g_cell
			rtv_div_cell u_hue_cell (
				.clk    (clk),
				.en     (en[gi+1]),
				.lane_d (hue_lane[gi]),
				.lane_q (hue_lane[gi+1])
			);
			rtv_div_cell u_sat_cell (
				.clk    (clk),
				.en     (en[gi+1]),
				.lane_d (sat_lane[gi]),
				.lane_q (sat_lane[gi+1])
			);
			always_ff @(posedge clk) begin
				if (en[gi+1]) begin
					side_q[gi] <= (gi == 0) ? side_s1 : side_q[(gi == 0) ? 0 : gi - 1];
				end
			end
		end
	endgenerate

	// Round half to even on the final quotient and remainder.
	always_comb begin
		hue_twice = {hue_lane[NCELL].rem, 1'b0};
		hue_den   = {1'b0, hue_lane[NCELL].den};
		hue_up    = (hue_twice > hue_den) ||
			((hue_twice == hue_den) && hue_lane[NCELL].quo[0]);
		hue_rnd   = hue_lane[NCELL].quo + CHAN_W'(hue_up);
		sat_twice = {sat_lane[NCELL].rem, 1'b0};
		sat_den   = {1'b0, sat_lane[NCELL].den};
		sat_up    = (sat_twice > sat_den) ||
			((sat_twice == sat_den) && sat_lane[NCELL].quo[0]);
		sat_rnd   = sat_lane[NCELL].quo + CHAN_W'(sat_up);
	end

	always_ff @(posedge clk) begin
		if (en[NSTAGE-1]) begin
			hue_q   <= side_q[NCELL-1].hue_zero ? '0 : hue_rnd;
			sat_q   <= side_q[NCELL-1].sat_zero ? '0 : sat_rnd;
			value_q <= side_q[NCELL-1].value;
		end
	end

	assign out_valid  = v_q[NSTAGE-1];
	assign hue        = hue_q;
	assign saturation = sat_q;
	assign value      = value_q;

	`RTV_ASSERT_IMP(a_hue_range, out_valid, hue <= HUE_MAX, "hue above half turn")
	`RTV_ASSERT_IMP(a_black_zero, out_valid && (value == '0), (saturation == '0) && (hue == '0), "black pixel with nonzero hue or saturation")
	`RTV_ASSERT_IMP(a_stall_full, in_stall, &v_q, "input stalled while a stage is empty")
	`RTV_ASSERT_NXT(a_accept_lands, in_valid && !in_stall, v_q[0], "accepted item missing from front stage")

endmodule

[design/rtv_div_cell.sv]
// One restoring division cell: one quotient bit per cell, registered.
`timescale 1ns / 1ps
module rtv_div_cell
	import rtv_pkg::*;
(
	input  logic  clk,
	input  logic  en,
	input  lane_t lane_d,
	output lane_t lane_q
);

	logic [CHAN_W:0] trial;
	logic [CHAN_W:0] den_x;
	logic [CHAN_W:0] diff;
	logic            ge;
	lane_t           nxt;

	always_comb begin
		trial = {lane_d.rem, lane_d.num_lo[CHAN_W-1]};
		den_x = {1'b0, lane_d.den};
		diff  = trial - den_x;
		ge    = (trial >= den_x);
		nxt.rem    = ge ? diff[CHAN_W-1:0] : trial[CHAN_W-1:0];
		nxt.num_lo = {lane_d.num_lo[CHAN_W-2:0], 1'b0};
		nxt.quo    = {lane_d.quo[CHAN_W-2:0], ge};
		nxt.den    = lane_d.den;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q <= nxt;
		end
	end

endmodule

[design/rtv_front.sv]
// Front stage: max, min, sector numerator and the two division lanes.
`timescale 1ns / 1ps
module rtv_front
	import rtv_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [CHAN_W-1:0] blue,
	input  logic [CHAN_W-1:0] green,
	input  logic [CHAN_W-1:0] red,
	output lane_t             hue_lane_s1,
	output lane_t             sat_lane_s1,
	output side_t             side_s1
);

	logic              red_top;
	logic              green_top;
	logic [CHAN_W-1:0] mx;
	logic [CHAN_W-1:0] mn;
	logic [CHAN_W-1:0] d;
	logic [N_W-1:0]    d_w;
	logic [N_W-1:0]    r_w;
	logic [N_W-1:0]    g_w;
	logic [N_W-1:0]    b_w;
	logic [N_W-1:0]    n;
	logic [NUM_W-1:0]  hue_num;
	logic [NUM_W-1:0]  sat_num;

	always_comb begin
		red_top   = (red >= green) && (red >= blue);
		green_top = !red_top && (green >= blue);
		mx = red_top ? red : (green_top ? green : blue);
		if ((red <= green) && (red <= blue)) begin
			mn = red;
		end else if (green <= blue) begin
			mn = green;
		end else begin
			mn = blue;
		end
		d   = mx - mn;
		d_w = N_W'(d);
		r_w = N_W'(red);
		g_w = N_W'(green);
		b_w = N_W'(blue);
		// Every sector offset keeps n non-negative, so modular math is exact.
		if (red_top) begin
			n = (green >= blue) ? (g_w - b_w) : (SECTOR_WRAP * d_w - (b_w - g_w));
		end else if (green_top) begin
			n = SECTOR_G * d_w + b_w - r_w;
		end else begin
			n = SECTOR_B * d_w + r_w - g_w;
		end
		hue_num = NUM_W'(n) * HUE_SCALE;
		sat_num = NUM_W'(d) * SAT_SCALE;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_lane_s1.rem    <= hue_num[NUM_W-1 -: CHAN_W];
			hue_lane_s1.num_lo <= hue_num[CHAN_W-1:0];
			hue_lane_s1.quo    <= '0;
			hue_lane_s1.den    <= d;
			sat_lane_s1.rem    <= sat_num[NUM_W-1 -: CHAN_W];
			sat_lane_s1.num_lo <= sat_num[CHAN_W-1:0];
			sat_lane_s1.quo    <= '0;
			sat_lane_s1.den    <= mx;
			side_s1.hue_zero   <= (d == '0);
			side_s1.sat_zero   <= (mx == '0);
			side_s1.value      <= mx;
		end
	end

endmodule
